// ----- hdl/salru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU tag model package
// Shared codes, field widths and the command and status types that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int ACTION_W  = 2;
  localparam int OUTCOME_W = 2;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SET_CFG_W  = 3;
  localparam int WAYS_CFG_W = 4;
  localparam int OFS_CFG_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_IFETCH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_MODIFY = 2'd3;

  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

  localparam logic [SET_CFG_W-1:0]  RST_SET_INDEX_BITS    = 3'd4;
  localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE       = 4'd1;
  localparam logic [OFS_CFG_W-1:0]  RST_BLOCK_OFFSET_BITS = 5'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic lookup;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/salru_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Access channel
// Carries one trace access per word: the action code and the byte address.
// ----------------------------------------------------------------------------
interface salru_in_if
  import salru_pkg::*;
#(
  parameter int ADDR_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

// ----- hdl/salru_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one lookup result per word together with the running totals.
// ----------------------------------------------------------------------------
interface salru_out_if
  import salru_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic                 last;
  logic [COUNT_W-1:0]   hit_total;
  logic [COUNT_W-1:0]   miss_total;
  logic [COUNT_W-1:0]   eviction_total;

  modport source (output valid, output outcome, output last, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink   (input valid, input outcome, input last, input hit_total,
                  input miss_total, input eviction_total, output ready);
endinterface

// ----- hdl/set_assoc_lru_cache_tag_model.sv -----
`timescale 1ns / 1ps
// A load or store is handled as a set read and then a compare and write-back on the single set
// memory, which loads the result register and waits while that register is full. A new access
// can be taken during the write-back of the last lookup; a modify makes two lookups in a row.
// An instruction fetch is accepted while the block is ready, starts no lookup and gives no result word.
// Reset (synchronous, active low) clears the controller, the totals, the result valid flag
// and the per-set written flags at once; configuration returns to 4 set bits, 1 way, 4 offset bits.
// ----------------------------------------------------------------------------
// Set-associative LRU cache tag model
// Top level: tag store of a set-associative cache with true LRU replacement
// that reports hit, miss or eviction for every lookup with running totals.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model
  import salru_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
)(
  input  logic                  clk,
  input  logic                  rst_n,
  salru_in_if.sink              in_ch,
  salru_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The controller steps through a read of the addressed set and then the
  // compare and write-back cycle. The datapath owns the set memory, in which
  // each row keeps the valid bits, tags and age ranks of one set. Rank 0
  // marks the most recently used way; the ranks of a set always form a
  // permutation of the way numbers. A row that was never written reads as
  // all ways invalid with ranks in way order, which a flag per row tracks.
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // The result register decouples the two sides: a new access is taken while
  // a finished word still waits, and a lookup only completes once the result
  // register has room for its word.
  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .status             (status),
    .in_address         (in_ch.address),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_outcome        (out_ch.outcome),
    .out_last           (out_ch.last),
    .out_hit_total      (out_ch.hit_total),
    .out_miss_total     (out_ch.miss_total),
    .out_eviction_total (out_ch.eviction_total)
  );

  assign in_ch.ready = in_ready;

  // An access that needs a lookup keeps the block busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.action != ACT_IFETCH) |=> !in_ch.ready)
    else $error("access accepted while a lookup is still in progress");

  // Every eviction is also counted as a miss, and both saturate alike.
  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.eviction_total <= out_ch.miss_total)
    else $error("eviction total exceeds miss total");

  // A hit word always carries a nonzero hit total.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.outcome == OUT_HIT) |-> out_ch.hit_total != '0)
    else $error("hit reported without a counted hit");

endmodule

// ----- hdl/salru_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU tag model controller
// Sequences each lookup as a set read followed by a compare and write-back,
// and repeats the pair for the second lookup of a modify.
// ----------------------------------------------------------------------------
module salru_ctrl
  import salru_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [ACTION_W-1:0] in_action,
  output logic                in_ready,
  output ctrl_cmd_t           cmd,
  input  dp_status_t          status
);

  ctrl_state_t state_r, state_nxt;
  logic        modify_r, modify_nxt;
  logic        second_r, second_nxt;
  logic        more_lookups;
  logic        accept;

  // A modify still owes its second lookup after the first one completes.
  assign more_lookups = modify_r && !second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      modify_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      modify_r <= modify_nxt;
      second_r <= second_nxt;
    end
  end

  // Output decode.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.last   = !more_lookups;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_LOOKUP: begin
        cmd.lookup = status.out_free;
        in_ready   = status.out_free && !more_lookups;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = in_ready && in_valid;
  end

  assign accept = in_ready && in_valid && (in_action != ACT_IFETCH);

  // Next state.
  always_comb begin
    state_nxt  = state_r;
    modify_nxt = modify_r;
    second_nxt = second_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_READ;
          modify_nxt = (in_action == ACT_MODIFY);
          second_nxt = 1'b0;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (status.out_free) begin
          if (more_lookups) begin
            state_nxt  = ST_READ;
            second_nxt = 1'b1;
          end else if (accept) begin
            state_nxt  = ST_READ;
            modify_nxt = (in_action == ACT_MODIFY);
            second_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/salru_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU tag model datapath
// Holds the configuration, the set memory, the tag compare and LRU update
// logic, the saturating totals and the result register.
// ----------------------------------------------------------------------------
module salru_dp
  import salru_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic [ADDR_BITS-1:0]  in_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUTCOME_W-1:0]  out_outcome,
  output logic                  out_last,
  output logic [COUNT_W-1:0]    out_hit_total,
  output logic [COUNT_W-1:0]    out_miss_total,
  output logic [COUNT_W-1:0]    out_eviction_total
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SHIFT_W  = OFS_CFG_W + 1;

  typedef logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row_t;
  typedef logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_row_t;

  // Configuration registers.
  logic [SET_CFG_W-1:0]  set_bits_r;
  logic [WAYS_CFG_W-1:0] ways_r;
  logic [OFS_CFG_W-1:0]  ofs_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= RST_SET_INDEX_BITS;
      ways_r     <= RST_WAYS_IN_USE;
      ofs_bits_r <= RST_BLOCK_OFFSET_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_INDEX_BITS:    set_bits_r <= cfg_wdata[SET_CFG_W-1:0];
        CFG_WAYS_IN_USE:       ways_r     <= cfg_wdata[WAYS_CFG_W-1:0];
        CFG_BLOCK_OFFSET_BITS: ofs_bits_r <= cfg_wdata[OFS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split.
  logic [ADDR_BITS-1:0] addr_r;
  logic [SET_CFG_W-1:0] set_bits_eff;
  logic [SET_W-1:0]     set_mask;
  logic [ADDR_BITS-1:0] addr_shifted;
  logic [SET_W-1:0]     set_idx;
  logic [SHIFT_W-1:0]   tag_shift;
  logic [ADDR_BITS-1:0] tag_calc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_address;
    end
  end

  assign set_bits_eff = (int'(set_bits_r) > MAX_SET_BITS) ? SET_CFG_W'(MAX_SET_BITS)
                                                           : set_bits_r;
  assign set_mask     = ~({SET_W{1'b1}} << set_bits_eff);
  assign addr_shifted = addr_r >> ofs_bits_r;
  assign set_idx      = addr_shifted[SET_W-1:0] & set_mask;
  assign tag_shift    = {1'b0, ofs_bits_r} + SHIFT_W'(set_bits_eff);
  assign tag_calc     = addr_r >> tag_shift;

  // Set memory: one row holds the valid bits, tags and age ranks of a set.
  logic [MAX_WAYS-1:0] mem_valid [NUM_SETS];
  tag_row_t            mem_tag   [NUM_SETS];
  rank_row_t           mem_rank  [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;

  logic [MAX_WAYS-1:0]  rd_valid_r;
  tag_row_t             rd_tag_r;
  rank_row_t            rd_rank_r;
  logic                 rd_init_r;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;

  logic [MAX_WAYS-1:0] new_valid;
  tag_row_t            new_tag;
  rank_row_t           new_rank;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_valid_r <= mem_valid[set_idx];
      rd_tag_r   <= mem_tag[set_idx];
      rd_rank_r  <= mem_rank[set_idx];
      set_r      <= set_idx;
      tag_r      <= tag_calc;
    end
    if (cmd.lookup) begin
      mem_valid[set_r] <= new_valid;
      mem_tag[set_r]   <= new_tag;
      mem_rank[set_r]  <= new_rank;
    end
  end

  // A row never written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
      rd_init_r  <= 1'b0;
    end else begin
      if (cmd.read) begin
        rd_init_r <= row_init_r[set_idx];
      end
      if (cmd.lookup) begin
        row_init_r[set_r] <= 1'b1;
      end
    end
  end

  // Tag compare, way selection and LRU update.
  logic [MAX_WAYS-1:0] eff_valid;
  rank_row_t           eff_rank;
  logic [MAX_WAYS-1:0] in_use;
  logic                hit;
  logic                free_found;
  logic [RANK_W-1:0]   hit_way;
  logic [RANK_W-1:0]   free_way;
  logic [RANK_W-1:0]   victim_way;
  logic [RANK_W-1:0]   oldest_rank;
  logic [RANK_W-1:0]   sel_way;
  logic [RANK_W-1:0]   sel_rank;
  logic [OUTCOME_W-1:0] outcome;

  always_comb begin
    hit         = 1'b0;
    free_found  = 1'b0;
    hit_way     = '0;
    free_way    = '0;
    victim_way  = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      eff_valid[w] = rd_init_r ? rd_valid_r[w] : 1'b0;
      eff_rank[w]  = rd_init_r ? rd_rank_r[w] : RANK_W'(w);
      in_use[w]    = (w == 0) || (w < int'(ways_r));
    end
    oldest_rank = eff_rank[0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit && in_use[w] && eff_valid[w] && (rd_tag_r[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (!free_found && in_use[w] && !eff_valid[w]) begin
        free_found = 1'b1;
        free_way   = RANK_W'(w);
      end
      if (in_use[w] && (eff_rank[w] > oldest_rank)) begin
        oldest_rank = eff_rank[w];
        victim_way  = RANK_W'(w);
      end
    end

    if (hit) begin
      sel_way = hit_way;
      outcome = OUT_HIT;
    end else if (free_found) begin
      sel_way = free_way;
      outcome = OUT_MISS;
    end else begin
      sel_way = victim_way;
      outcome = OUT_EVICT;
    end

    sel_rank = eff_rank[sel_way];
    new_valid = eff_valid;
    new_tag   = rd_tag_r;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (RANK_W'(w) == sel_way) begin
        new_rank[w]  = '0;
        new_valid[w] = 1'b1;
        new_tag[w]   = tag_r;
      end else if (eff_rank[w] < sel_rank) begin
        new_rank[w] = eff_rank[w] + RANK_W'(1);
      end else begin
        new_rank[w] = eff_rank[w];
      end
    end
  end

  // Saturating totals; they change only when a new result is loaded, so the
  // result word reads them directly.
  logic [COUNT_W-1:0] hit_cnt_r;
  logic [COUNT_W-1:0] miss_cnt_r;
  logic [COUNT_W-1:0] evict_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (cmd.lookup) begin
      if (hit) begin
        if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + COUNT_W'(1);
      end else begin
        if (miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + COUNT_W'(1);
        if (!free_found && (evict_cnt_r != '1)) begin
          evict_cnt_r <= evict_cnt_r + COUNT_W'(1);
        end
      end
    end
  end

  // Result register.
  logic                 out_valid_r;
  logic [OUTCOME_W-1:0] outcome_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.lookup) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      outcome_r <= outcome;
      last_r    <= cmd.last;
    end
  end

  assign status.out_free    = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_last           = last_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

endmodule

// ----- bench/set_assoc_lru_cache_tag_model_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache tag model testbench
// Sends trace accesses (fetch, load, store, modify) through the access channel
// under a run of cache geometries and idle patterns. A true-LRU tag store kept
// in the bench predicts the outcome and the running totals of every lookup,
// and each result word is checked field by field, in order, against it or a hand-written word.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model_tb;
  import salru_pkg::*;

  localparam int SET_BITS_MAX = 6;
  localparam int WAYS_MAX     = 8;
  localparam int ADDR_W       = 32;
  localparam int NUM_SETS     = 1 << SET_BITS_MAX;
  localparam int RANK_W       = $clog2(WAYS_MAX);

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  // Wait after the last owed word is in, so that the block is seen idle again.
  localparam int SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS  = 100;

  localparam logic [6:0] IDLE_NONE  = 7'd0;
  localparam logic [6:0] IDLE_LIGHT = 7'd19;
  localparam logic [6:0] IDLE_HEAVY = 7'd80;

  // One result word as the receiver sees it.
  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 last;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
    logic [COUNT_W-1:0]   evictions;
  } lookup_word_t;

  // A row of the directed table. Where typed is set, word is the result that
  // the access must give, written out by hand; otherwise the predictor decides.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic                typed;
    lookup_word_t        word;
  } access_row_t;

  // One random phase: the geometry written before it, how often each side
  // idles, how many lookups it sends, and whether it stops halfway to let the
  // block empty out.
  typedef struct packed {
    logic [SET_CFG_W-1:0]  set_bits;
    logic [WAYS_CFG_W-1:0] ways;
    logic [OFS_CFG_W-1:0]  offset_bits;
    logic [6:0]            sender_idle;
    logic [6:0]            receiver_stall;
    logic [15:0]           lookups;
    logic                  drain_midway;
  } phase_t;

  localparam lookup_word_t NO_WORD = '0;

  // Directed part, run with the reset geometry: 16 sets, one way, 16-byte
  // blocks. The first rows are simple enough to write the result down.
  localparam int NUM_ROWS = 16;
  localparam access_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    '{ACT_LOAD,   32'h0000_0000, 1'b1, '{OUT_MISS,  1'b1, 32'd0, 32'd1, 32'd0}},
    '{ACT_LOAD,   32'h0000_000F, 1'b1, '{OUT_HIT,   1'b1, 32'd1, 32'd1, 32'd0}},
    '{ACT_STORE,  32'h0000_0010, 1'b1, '{OUT_MISS,  1'b1, 32'd1, 32'd2, 32'd0}},
    '{ACT_IFETCH, 32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{ACT_LOAD,   32'h0000_0100, 1'b1, '{OUT_EVICT, 1'b1, 32'd1, 32'd3, 32'd1}},
    '{ACT_MODIFY, 32'h0000_0100, 1'b0, NO_WORD},
    '{ACT_MODIFY, 32'h0000_0000, 1'b0, NO_WORD},
    '{ACT_LOAD,   32'hFFFF_FFFF, 1'b0, NO_WORD},
    '{ACT_STORE,  32'hFFFF_FFF0, 1'b0, NO_WORD},
    '{ACT_MODIFY, 32'h8000_0000, 1'b0, NO_WORD},
    '{ACT_IFETCH, 32'h0000_0000, 1'b0, NO_WORD},
    '{ACT_LOAD,   32'h7FFF_FFFF, 1'b0, NO_WORD},
    '{ACT_STORE,  32'hAAAA_AAAA, 1'b0, NO_WORD},
    '{ACT_LOAD,   32'h5555_5555, 1'b0, NO_WORD},
    '{ACT_MODIFY, 32'h0000_0010, 1'b0, NO_WORD},
    '{ACT_LOAD,   32'h0000_FFF0, 1'b0, NO_WORD}
  };

  // Random phases. The geometry changes between phases without clearing the
  // tag store, so every phase also starts on lines left over from the last
  // one. Out of range settings are in the list: zero set bits, set bits above
  // the maximum, zero ways, ways above the maximum, and offsets so wide that
  // the set and tag fields run off the top of the address.
  localparam int NUM_PHASES = 11;
  localparam phase_t PHASES [0:NUM_PHASES-1] = '{
    '{3'd2, 4'd4,  5'd4,  IDLE_NONE,  IDLE_NONE,  16'd200, 1'b1},
    '{3'd0, 4'd8,  5'd3,  IDLE_HEAVY, IDLE_NONE,  16'd150, 1'b0},
    '{3'd7, 4'd15, 5'd0,  IDLE_NONE,  IDLE_HEAVY, 16'd150, 1'b0},
    '{3'd3, 4'd0,  5'd26, IDLE_LIGHT, IDLE_LIGHT, 16'd150, 1'b1},
    '{3'd6, 4'd8,  5'd31, IDLE_NONE,  IDLE_NONE,  16'd120, 1'b0},
    '{3'd5, 4'd2,  5'd28, IDLE_HEAVY, IDLE_NONE,  16'd120, 1'b0},
    '{3'd1, 4'd3,  5'd5,  IDLE_LIGHT, IDLE_LIGHT, 16'd150, 1'b0},
    '{3'd4, 4'd8,  5'd2,  IDLE_NONE,  IDLE_HEAVY, 16'd150, 1'b1},
    '{3'd6, 4'd7,  5'd6,  IDLE_NONE,  IDLE_NONE,  16'd150, 1'b0},
    '{3'd0, 4'd1,  5'd0,  IDLE_LIGHT, IDLE_LIGHT, 16'd100, 1'b0},
    '{3'd4, 4'd5,  5'd4,  IDLE_NONE,  IDLE_NONE,  16'd100, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  salru_in_if #(.ADDR_BITS(ADDR_W)) in_ch ();
  salru_out_if out_ch ();

  set_assoc_lru_cache_tag_model #(
    .MAX_SET_BITS (SET_BITS_MAX),
    .MAX_WAYS     (WAYS_MAX),
    .ADDR_BITS    (ADDR_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the tag store, the totals and the geometry registers.
  // --------------------------------------------------------------------------
  logic                  line_present [NUM_SETS][WAYS_MAX];
  logic [ADDR_W-1:0]     stored_tag   [NUM_SETS][WAYS_MAX];
  logic [RANK_W-1:0]     age_rank     [NUM_SETS][WAYS_MAX];
  logic [COUNT_W-1:0]    hit_total_q;
  logic [COUNT_W-1:0]    miss_total_q;
  logic [COUNT_W-1:0]    evict_total_q;
  logic [SET_CFG_W-1:0]  set_bits_reg;
  logic [WAYS_CFG_W-1:0] ways_reg;
  logic [OFS_CFG_W-1:0]  offset_bits_reg;

  // Result words still owed by the block, oldest first.
  lookup_word_t expected_words [$];

  int          error_count = 0;
  int          words_checked = 0;
  int          accesses_sent = 0;
  int          hit_words = 0;
  int          fill_words = 0;
  int          evict_words = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic void reset_predictor();
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < WAYS_MAX; w++) begin
        line_present[s][w] = 1'b0;
        stored_tag[s][w]   = '0;
        age_rank[s][w]     = RANK_W'(w);
      end
    end
    hit_total_q     = '0;
    miss_total_q    = '0;
    evict_total_q   = '0;
    set_bits_reg    = RST_SET_INDEX_BITS;
    ways_reg        = RST_WAYS_IN_USE;
    offset_bits_reg = RST_BLOCK_OFFSET_BITS;
  endfunction

  // Set bits in use: anything above the maximum counts as the maximum.
  function automatic int unsigned live_set_bits();
    if (set_bits_reg > SET_BITS_MAX) return SET_BITS_MAX;
    return set_bits_reg;
  endfunction

  // Ways in use: zero counts as one, anything above the maximum as the maximum.
  function automatic int unsigned live_ways();
    if (ways_reg == 0) return 1;
    if (ways_reg > WAYS_MAX) return WAYS_MAX;
    return ways_reg;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Every way younger than the touched one ages by one; the touched way
  // becomes rank zero. All ways of the set take part, used or not.
  function automatic void make_youngest(input int unsigned set_no, input int unsigned way);
    logic [RANK_W-1:0] r;
    r = age_rank[set_no][way];
    for (int w = 0; w < WAYS_MAX; w++) begin
      if (age_rank[set_no][w] < r) age_rank[set_no][w] = age_rank[set_no][w] + 1'b1;
    end
    age_rank[set_no][way] = '0;
  endfunction

  function automatic logic [OUTCOME_W-1:0] cache_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned       s;
    int unsigned       e;
    int unsigned       b;
    int unsigned       set_no;
    int unsigned       victim;
    logic [63:0]       wide;
    logic [63:0]       tag;
    logic [RANK_W-1:0] oldest;
    s = live_set_bits();
    e = live_ways();
    b = offset_bits_reg;
    // Work in 64 bits: with a wide offset the set and tag fields can start
    // above bit 31, and then both come out as zero.
    wide   = {32'd0, addr};
    set_no = int'((wide >> b) & ((64'd1 << s) - 64'd1));
    tag    = wide >> (b + s);
    for (int w = 0; w < e; w++) begin
      if (line_present[set_no][w] && stored_tag[set_no][w] == tag[ADDR_W-1:0]) begin
        hit_total_q = bump(hit_total_q);
        make_youngest(set_no, w);
        return OUT_HIT;
      end
    end
    miss_total_q = bump(miss_total_q);
    // The lowest free way is filled first.
    for (int w = 0; w < e; w++) begin
      if (!line_present[set_no][w]) begin
        line_present[set_no][w] = 1'b1;
        stored_tag[set_no][w]   = tag[ADDR_W-1:0];
        make_youngest(set_no, w);
        return OUT_MISS;
      end
    end
    // Set full: replace the oldest way in use, the lowest one on a tie.
    victim = 0;
    oldest = age_rank[set_no][0];
    for (int w = 1; w < e; w++) begin
      if (age_rank[set_no][w] > oldest) begin
        oldest = age_rank[set_no][w];
        victim = w;
      end
    end
    evict_total_q = bump(evict_total_q);
    stored_tag[set_no][victim] = tag[ADDR_W-1:0];
    make_youngest(set_no, victim);
    return OUT_EVICT;
  endfunction

  // Works out the words that an accepted access owes and queues them. A fetch
  // owes nothing; a modify looks the same address up twice.
  function automatic void predict_access(input logic [ACTION_W-1:0] act,
                                         input logic [ADDR_W-1:0] addr);
    lookup_word_t w;
    int           passes;
    if (act == ACT_IFETCH) return;
    passes = (act == ACT_MODIFY) ? 2 : 1;
    for (int p = 0; p < passes; p++) begin
      w.outcome   = cache_lookup(addr);
      w.last      = (p == passes - 1);
      w.hits      = hit_total_q;
      w.misses    = miss_total_q;
      w.evictions = evict_total_q;
      expected_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Access side. Everything is driven with nonblocking assignments right
  // after a rising edge, and ready is read at the edge, so an access counts
  // as taken at exactly the edge the block sees valid and ready high.
  // --------------------------------------------------------------------------
  task automatic send_access(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accesses_sent++;
  endtask

  // Holds the sender off until every owed word is in, then lets a fetch that
  // may still be in the pipe drain out as well.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_SET_INDEX_BITS:    set_bits_reg    = value[SET_CFG_W-1:0];
      CFG_WAYS_IN_USE:       ways_reg        = value[WAYS_CFG_W-1:0];
      CFG_BLOCK_OFFSET_BITS: offset_bits_reg = value[OFS_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Random accesses shaped for the current geometry. Most addresses are built
  // from a small pool of tags over a few hot sets, a couple more tags than
  // there are ways, so hits, fills and evictions all come often. The rest are
  // fully random addresses, which also toggle every address bit.
  task automatic run_random_phase(input phase_t ph);
    logic [ADDR_W-1:0]   tag_pool [0:WAYS_MAX+1];
    logic [ADDR_W-1:0]   addr;
    logic [63:0]         wide;
    logic [ACTION_W-1:0] act;
    int unsigned         s;
    int unsigned         b;
    int unsigned         pool_size;
    int unsigned         hot_top;
    int unsigned         set_no;
    int unsigned         pick;
    int unsigned         lookups_done;
    s         = live_set_bits();
    b         = offset_bits_reg;
    pool_size = live_ways() + 2;
    hot_top   = (1 << s) - 1;
    if (hot_top > 3) hot_top = 3;
    for (int i = 0; i < pool_size; i++) tag_pool[i] = $urandom;
    lookups_done = 0;
    while (lookups_done < ph.lookups) begin
      pick = $urandom_range(99);
      if (pick < 8) act = ACT_IFETCH;
      else if (pick < 38) act = ACT_LOAD;
      else if (pick < 68) act = ACT_STORE;
      else act = ACT_MODIFY;
      if ($urandom_range(99) < 20) begin
        addr = $urandom;
      end else begin
        set_no = ($urandom_range(99) < 70) ? $urandom_range(hot_top)
                                           : $urandom_range((1 << s) - 1);
        wide = ({32'd0, tag_pool[$urandom_range(pool_size - 1)]} << (b + s))
             | (64'(set_no) << b)
             | ({32'd0, $urandom} & ((64'd1 << b) - 64'd1));
        addr = wide[ADDR_W-1:0];
      end
      send_access(act, addr);
      predict_access(act, addr);
      if (act != ACT_IFETCH) begin
        lookups_done++;
        // Halfway through some phases the sender waits for the block to
        // empty completely before it goes on.
        if (ph.drain_midway && lookups_done == ph.lookups / 2) wait_until_drained();
      end
    end
    wait_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Result side: a random ready, and an in-order check of each word taken.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_word();
    lookup_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with outcome %0d arrived with nothing owed",
                                out_ch.outcome));
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (out_ch.outcome !== want.outcome)
      report_mismatch($sformatf("word %0d outcome %0d, want %0d",
                                words_checked, out_ch.outcome, want.outcome));
    if (out_ch.last !== want.last)
      report_mismatch($sformatf("word %0d last %0b, want %0b",
                                words_checked, out_ch.last, want.last));
    if (out_ch.hit_total !== want.hits)
      report_mismatch($sformatf("word %0d hit_total %0d, want %0d",
                                words_checked, out_ch.hit_total, want.hits));
    if (out_ch.miss_total !== want.misses)
      report_mismatch($sformatf("word %0d miss_total %0d, want %0d",
                                words_checked, out_ch.miss_total, want.misses));
    if (out_ch.eviction_total !== want.evictions)
      report_mismatch($sformatf("word %0d eviction_total %0d, want %0d",
                                words_checked, out_ch.eviction_total, want.evictions));
    case (want.outcome)
      OUT_HIT:   hit_words++;
      OUT_MISS:  fill_words++;
      OUT_EVICT: evict_words++;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) check_word();
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d words still owed",
             cycle_count, expected_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SET_INDEX_BITS;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_IFETCH;
    in_ch.address = '0;
    out_ch.ready  = 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed accesses at full rate on the reset geometry. Hand-written
    // results replace the predicted word, while the predictor still follows
    // the access so that its state stays in step.
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_access(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].address);
      predict_access(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].address);
      if (DIRECTED_ROWS[i].typed)
        expected_words[expected_words.size() - 1] = DIRECTED_ROWS[i].word;
    end
    wait_until_drained();

    // Each phase rewrites all three registers while the block is idle, then
    // runs its random accesses under its own idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_SET_INDEX_BITS,    CFG_DATA_W'(PHASES[p].set_bits));
      write_reg(CFG_WAYS_IN_USE,       CFG_DATA_W'(PHASES[p].ways));
      write_reg(CFG_BLOCK_OFFSET_BITS, CFG_DATA_W'(PHASES[p].offset_bits));
      cfg_we <= 1'b0;
      sender_idle_pct    = PHASES[p].sender_idle;
      receiver_stall_pct = PHASES[p].receiver_stall;
      run_random_phase(PHASES[p]);
    end

    $display("Sent %0d accesses over %0d geometries; %0d result words checked",
             accesses_sent, NUM_PHASES + 1, words_checked);
    $display("Outcomes seen: %0d hits, %0d fills into a free way, %0d evictions",
             hit_words, fill_words, evict_words);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/salru_pkg.sv
hdl/salru_in_if.sv
hdl/salru_out_if.sv
hdl/salru_ctrl.sv
hdl/salru_dp.sv
hdl/set_assoc_lru_cache_tag_model.sv
bench/set_assoc_lru_cache_tag_model_tb.sv
